>>> hw/rtl/identifier_name_mangler_assert.svh
// Assertion macros for the identifier name mangler
`ifndef IDENTIFIER_NAME_MANGLER_ASSERT_SVH
`define IDENTIFIER_NAME_MANGLER_ASSERT_SVH

// checked outside reset
`define IDMANG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define IDMANG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/idmang_pkg.sv
package idmang_pkg;

  localparam int WIN_DEPTH = 3;
  localparam int CNT_W     = 2;
  localparam int TQ_DEPTH  = 4;
  localparam int TQ_AW     = $clog2(TQ_DEPTH);
  localparam int TQ_CW     = $clog2(TQ_DEPTH + 1);

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_X          = 8'h78;

  // one decided byte of the name
  typedef struct packed {
    logic [7:0] chr;
    logic       escape;
    logic       last;
  } token_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h61) && (c <= 8'h7A)) || (c == CH_UNDERSCORE);
  endfunction

  function automatic logic is_upper_hex(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) begin
      r = 8'h30 + {4'h0, n};
    end else begin
      r = 8'h37 + {4'h0, n};
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/identifier_name_mangler.sv
// Decision: a byte is decided once three later bytes or the final byte are in;
//   its token goes into the queue, then into the expander's output register.
//   After the final byte the window drains into the queue, with full held high.
// Output: one output byte per cycle from the expander while pop is held and
//   tokens are queued; a plain byte gives one output byte, an escaped byte four.
// Reset (rst, synchronous): window and queue empty, next byte starts a name.
module identifier_name_mangler (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       final_flag,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       end_of_name
);

  logic               tok_vld;
  idmang_pkg::token_t tok;
  logic               q_full;
  logic               q_rd;
  idmang_pkg::token_t q_tok;
  logic               q_nonempty;

  idmang_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .in_byte    (in_byte),
    .final_flag (final_flag),
    .tok_vld    (tok_vld),
    .tok        (tok),
    .q_full     (q_full)
  );

  idmang_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (tok_vld),
    .wr_tok     (tok),
    .q_full     (q_full),
    .rd_en      (q_rd),
    .rd_tok     (q_tok),
    .q_nonempty (q_nonempty)
  );

  idmang_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_nonempty  (q_nonempty),
    .q_tok       (q_tok),
    .q_rd        (q_rd),
    .empty       (empty),
    .pop         (pop),
    .out_byte    (out_byte),
    .end_of_name (end_of_name)
  );

endmodule

>>> hw/rtl/idmang_front.sv
module idmang_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [7:0]            in_byte,
  input  logic                  final_flag,
  output logic                  tok_vld,
  output idmang_pkg::token_t    tok,
  input  logic                  q_full
);

  logic [7:0]                   win [idmang_pkg::WIN_DEPTH];
  logic [7:0]                   win_next [idmang_pkg::WIN_DEPTH];
  logic [idmang_pkg::CNT_W-1:0] cnt, cnt_next;
  logic                         start, start_next;
  logic                         flushing, flushing_next;
  logic                         acc;

  assign full = flushing || q_full;
  assign acc  = push && !full;

  always_comb begin
    win_next      = win;
    cnt_next      = cnt;
    start_next    = start;
    flushing_next = flushing;
    tok_vld       = 1'b0;
    tok           = '0;
    if (flushing) begin
      // drain window; lookahead is short here so the underscore rule never fires
      if (!q_full) begin
        tok_vld     = 1'b1;
        tok.chr     = win[0];
        tok.escape  = !idmang_pkg::is_word(win[0]) ||
                      (start && idmang_pkg::is_digit(win[0]));
        tok.last    = (cnt == 2'd1);
        win_next[0] = win[1];
        win_next[1] = win[2];
        win_next[2] = 8'h00;
        cnt_next    = cnt - 2'd1;
        start_next  = 1'b0;
        if (cnt == 2'd1) begin
          flushing_next = 1'b0;
          start_next    = 1'b1;
        end
      end
    end else if (acc) begin
      if (cnt == 2'd3) begin
        tok_vld     = 1'b1;
        tok.chr     = win[0];
        tok.escape  = !idmang_pkg::is_word(win[0]) ||
                      (start && idmang_pkg::is_digit(win[0])) ||
                      ((win[0] == idmang_pkg::CH_UNDERSCORE) &&
                       (win[1] == idmang_pkg::CH_X) &&
                       idmang_pkg::is_upper_hex(win[2]) &&
                       idmang_pkg::is_upper_hex(in_byte));
        tok.last    = 1'b0;
        win_next[0] = win[1];
        win_next[1] = win[2];
        win_next[2] = in_byte;
        start_next  = 1'b0;
      end else begin
        win_next[cnt] = in_byte;
        cnt_next      = cnt + 2'd1;
      end
      if (final_flag) begin
        flushing_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      start    <= 1'b1;
      flushing <= 1'b0;
      win[0]   <= 8'h00;
      win[1]   <= 8'h00;
      win[2]   <= 8'h00;
    end else begin
      cnt      <= cnt_next;
      start    <= start_next;
      flushing <= flushing_next;
      win      <= win_next;
    end
  end

endmodule

>>> hw/rtl/idmang_queue.sv
module idmang_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  idmang_pkg::token_t wr_tok,
  output logic               q_full,
  input  logic               rd_en,
  output idmang_pkg::token_t rd_tok,
  output logic               q_nonempty
);

  idmang_pkg::token_t            mem [idmang_pkg::TQ_DEPTH];
  logic [idmang_pkg::TQ_AW-1:0]  wr_ptr, rd_ptr;
  logic [idmang_pkg::TQ_CW-1:0]  count;
  logic                          do_wr, do_rd;

  assign q_full     = (count == idmang_pkg::TQ_CW'(idmang_pkg::TQ_DEPTH));
  assign q_nonempty = (count != '0);
  assign rd_tok     = mem[rd_ptr];
  assign do_wr      = wr_en && !q_full;
  assign do_rd      = rd_en && q_nonempty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/idmang_back.sv
module idmang_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_nonempty,
  input  idmang_pkg::token_t q_tok,
  output logic               q_rd,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         out_byte,
  output logic               end_of_name
);

  idmang_pkg::token_t cur;
  logic               cur_vld;
  logic [1:0]         phase;
  logic               last_phase;
  logic               load;

  assign last_phase = !cur.escape || (phase == 2'd3);
  assign load       = !cur_vld || (pop && last_phase);
  assign q_rd       = load && q_nonempty;
  assign empty      = !cur_vld;

  always_comb begin
    if (!cur.escape) begin
      out_byte = cur.chr;
    end else begin
      case (phase)
        2'd0:    out_byte = idmang_pkg::CH_UNDERSCORE;
        2'd1:    out_byte = idmang_pkg::CH_X;
        2'd2:    out_byte = idmang_pkg::hex_char(cur.chr[7:4]);
        default: out_byte = idmang_pkg::hex_char(cur.chr[3:0]);
      endcase
    end
  end

  assign end_of_name = cur.last && last_phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_vld <= 1'b0;
      phase   <= '0;
    end else if (load) begin
      cur_vld <= q_nonempty;
      phase   <= '0;
    end else if (pop) begin
      phase <= phase + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= q_tok;
    end
  end

endmodule

>>> hw/rtl/idmang_checker.sv
`include "identifier_name_mangler_assert.svh"

module idmang_checker (
  input logic       clk,
  input logic       rst,
  input logic       push,
  input logic       full,
  input logic       final_flag,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       end_of_name
);

  `IDMANG_ASSERT_ALWAYS(a_empty_after_rst, rst |=> empty, "result side not empty after reset")
  `IDMANG_ASSERT(a_out_hold, (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(end_of_name)), "waiting result changed")
  `IDMANG_ASSERT(a_no_nul, !empty |-> (out_byte != 8'h00), "NUL byte in mangled name")
  `IDMANG_ASSERT(a_full_on_final, (push && !full && final_flag) |=> full, "input not held off while draining")

endmodule

bind identifier_name_mangler idmang_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .push        (push),
  .full        (full),
  .final_flag  (final_flag),
  .empty       (empty),
  .pop         (pop),
  .out_byte    (out_byte),
  .end_of_name (end_of_name)
);
